[rtl/imu_mount_rotate_bias_lowpass_defines.svh]
// ----------------------------------------------------------------------------
// IMU mount/bias/low-pass: assertion macros
// Shared assertion forms for the checker; clock is clk, reset is rst_n.
// ----------------------------------------------------------------------------
`ifndef IMU_MOUNT_ROTATE_BIAS_LOWPASS_DEFINES_SVH
`define IMU_MOUNT_ROTATE_BIAS_LOWPASS_DEFINES_SVH

// checked only outside reset
`define IMR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define IMR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/imr_pkg.sv]
// ----------------------------------------------------------------------------
// IMU mount/bias/low-pass: package
// Payload types, filter coefficients, register indexes and saturation.
// ----------------------------------------------------------------------------
package imr_pkg;

    localparam int DATA_W = 32;
    localparam int ACC_W  = 64;
    localparam int C2X_W  = 54;
    localparam int C1H_W  = 62;
    localparam int C0H_W  = 63;
    localparam int ADDR_W = 3;
    localparam int FRAC_SHIFT = 30;

    localparam int QUEUE_DEPTH_DEF = 2;

    // 1: x' = y, y' = -x, z' = z; 0: no rotation
    localparam int MOUNT_ORIENTATION = 1;

    // Q2.30, sum is exactly 2^30
    localparam logic signed [31:0] COEF_C0 = 32'sd2071735500;
    localparam logic signed [31:0] COEF_C1 = -32'sd1000494913;
    localparam logic signed [22:0] COEF_C2 = 23'sd2501237;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd536870912;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    localparam logic [ADDR_W-1:0] REG_GYRO_BIAS_X  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_GYRO_BIAS_Y  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_GYRO_BIAS_Z  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_ACCEL_BIAS_X = 3'd3;
    localparam logic [ADDR_W-1:0] REG_ACCEL_BIAS_Y = 3'd4;
    localparam logic [ADDR_W-1:0] REG_ACCEL_BIAS_Z = 3'd5;

    typedef struct packed {
        logic signed [DATA_W-1:0] raw_gyro_x;
        logic signed [DATA_W-1:0] raw_gyro_y;
        logic signed [DATA_W-1:0] raw_gyro_z;
        logic signed [DATA_W-1:0] raw_accel_x;
        logic signed [DATA_W-1:0] raw_accel_y;
        logic signed [DATA_W-1:0] raw_accel_z;
        logic                     preload;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] cal_gyro_x;
        logic signed [DATA_W-1:0] cal_gyro_y;
        logic signed [DATA_W-1:0] cal_gyro_z;
        logic signed [DATA_W-1:0] cal_accel_x;
        logic signed [DATA_W-1:0] cal_accel_y;
        logic signed [DATA_W-1:0] cal_accel_z;
        logic signed [DATA_W-1:0] filt_accel_x;
        logic signed [DATA_W-1:0] filt_accel_y;
        logic signed [DATA_W-1:0] filt_accel_z;
    } out_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } triple_t;

    typedef struct packed {
        triple_t                    gyro;
        triple_t                    accel;
        logic [2:0][C2X_W-1:0]      c2x;
        logic                       preload;
    } q_entry_t;

    function automatic logic signed [DATA_W-1:0] sat34(input logic signed [33:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 34'sd2147483647)
            r = Q_MAX;
        else if (v < -34'sd2147483648)
            r = Q_MIN;
        else
            r = DATA_W'(v);
        return r;
    endfunction

    function automatic triple_t rotate_bias(input triple_t raw, input triple_t bias);
        logic signed [33:0] r0;
        logic signed [33:0] r1;
        logic signed [33:0] r2;
        triple_t res;
        if (MOUNT_ORIENTATION == 1)
        begin
            r0 = 34'(raw.y);
            r1 = -34'(raw.x);
        end
        else
        begin
            r0 = 34'(raw.x);
            r1 = 34'(raw.y);
        end
        r2 = 34'(raw.z);
        res.x = sat34(r0 + 34'(bias.x));
        res.y = sat34(r1 + 34'(bias.y));
        res.z = sat34(r2 + 34'(bias.z));
        return res;
    endfunction

endpackage

[rtl/imu_mount_rotate_bias_lowpass.sv]
// ----------------------------------------------------------------------------
// IMU mount/bias/low-pass: top level
// Rotates gyro and accel by the board mount, adds bias, low-pass filters accel.
// ----------------------------------------------------------------------------
// Takes one transfer per clock while not stalled and gives one result per
// transfer, in order. Sustained rate is one item per cycle while out_stall
// is low, set by the per-axis filter feedback (one 32x32 multiply by C0 plus
// one add of the stored partial sums per cycle). A front end (two stages:
// rotate/bias/saturate, then the x*C2 product) feeds a QUEUE_DEPTH-entry FIFO;
// the filter back end drains it into an output register, so either side may
// stall without blocking the other. Bias registers 0..5 (gyro x/y/z, accel
// x/y/z) are written through the cfg port, by the user only while idle, which
// the block does not enforce; other indexes are ignored. A preload item seeds
// the filter history with its calibrated accel and returns that as filt_accel.
module imu_mount_rotate_bias_lowpass
#(
    parameter int QUEUE_DEPTH = imr_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [imr_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [imr_pkg::DATA_W-1:0]  cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  imr_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output imr_pkg::out_item_t          out_data
);
    import imr_pkg::*;

    logic     push_valid;
    logic     push_ready;
    q_entry_t push_data;
    logic     q_valid;
    logic     q_pop;
    q_entry_t q_data;

    imr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    imr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_en     (q_pop),
        .pop_data   (q_data)
    );

    imr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[rtl/imr_front.sv]
// ----------------------------------------------------------------------------
// IMU mount/bias/low-pass: front end
// Bias registers, rotation and bias add, then the feed-forward filter product.
// ----------------------------------------------------------------------------
module imr_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [imr_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [imr_pkg::DATA_W-1:0]   cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  imr_pkg::in_item_t            in_data,
    output logic                         push_valid,
    input  logic                         push_ready,
    output imr_pkg::q_entry_t            push_data
);
    import imr_pkg::*;

    triple_t  gyro_bias_reg;
    triple_t  accel_bias_reg;

    logic     a_valid_reg;
    triple_t  a_gyro_reg;
    triple_t  a_accel_reg;
    logic     a_preload_reg;

    logic     b_valid_reg;
    q_entry_t b_entry_reg;
    q_entry_t b_entry_next;

    logic     a_take;
    logic     b_take;
    triple_t  raw_gyro;
    triple_t  raw_accel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_bias_reg  <= '0;
            accel_bias_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_GYRO_BIAS_X:  gyro_bias_reg.x  <= cfg_wdata;
                REG_GYRO_BIAS_Y:  gyro_bias_reg.y  <= cfg_wdata;
                REG_GYRO_BIAS_Z:  gyro_bias_reg.z  <= cfg_wdata;
                REG_ACCEL_BIAS_X: accel_bias_reg.x <= cfg_wdata;
                REG_ACCEL_BIAS_Y: accel_bias_reg.y <= cfg_wdata;
                REG_ACCEL_BIAS_Z: accel_bias_reg.z <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    assign b_take   = !b_valid_reg || push_ready;
    assign a_take   = !a_valid_reg || b_take;
    assign in_stall = !a_take;

    assign raw_gyro.x  = in_data.raw_gyro_x;
    assign raw_gyro.y  = in_data.raw_gyro_y;
    assign raw_gyro.z  = in_data.raw_gyro_z;
    assign raw_accel.x = in_data.raw_accel_x;
    assign raw_accel.y = in_data.raw_accel_y;
    assign raw_accel.z = in_data.raw_accel_z;

    always_comb
    begin
        b_entry_next.gyro    = a_gyro_reg;
        b_entry_next.accel   = a_accel_reg;
        b_entry_next.preload = a_preload_reg;
        b_entry_next.c2x[0]  = C2X_W'(COEF_C2) * C2X_W'(a_accel_reg.x);
        b_entry_next.c2x[1]  = C2X_W'(COEF_C2) * C2X_W'(a_accel_reg.y);
        b_entry_next.c2x[2]  = C2X_W'(COEF_C2) * C2X_W'(a_accel_reg.z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_take)
                a_valid_reg <= in_valid;
            if (b_take)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take && in_valid)
        begin
            a_gyro_reg    <= rotate_bias(raw_gyro, gyro_bias_reg);
            a_accel_reg   <= rotate_bias(raw_accel, accel_bias_reg);
            a_preload_reg <= in_data.preload;
        end
        if (b_take && a_valid_reg)
            b_entry_reg <= b_entry_next;
    end

    assign push_valid = b_valid_reg;
    assign push_data  = b_entry_reg;

endmodule

[rtl/imr_queue.sv]
// ----------------------------------------------------------------------------
// IMU mount/bias/low-pass: decoupling queue
// Small FIFO between front end and filter back end.
// ----------------------------------------------------------------------------
module imr_queue
#(
    parameter int DEPTH = imr_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  imr_pkg::q_entry_t  push_data,
    output logic               pop_valid,
    input  logic               pop_en,
    output imr_pkg::q_entry_t  pop_data
);
    import imr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_en && pop_valid;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/imr_back.sv]
// ----------------------------------------------------------------------------
// IMU mount/bias/low-pass: filter back end
// Per-axis IIR step with history feedback, output register.
// ----------------------------------------------------------------------------
module imr_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  imr_pkg::q_entry_t  q_data,
    output logic               out_valid,
    input  logic               out_stall,
    output imr_pkg::out_item_t out_data
);
    import imr_pkg::*;

    // h1 and C1*h2 per axis; h2 itself is only ever needed times C1
    logic signed [DATA_W-1:0] h1_reg   [3];
    logic signed [C1H_W-1:0]  c1h2_reg [3];

    logic signed [DATA_W-1:0] accel    [3];
    logic signed [C0H_W-1:0]  m0       [3];
    logic signed [C1H_W-1:0]  m1       [3];
    logic signed [ACC_W-1:0]  acc      [3];
    logic signed [DATA_W-1:0] filt     [3];

    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t out_data_next;

    assign accel[0] = q_data.accel.x;
    assign accel[1] = q_data.accel.y;
    assign accel[2] = q_data.accel.z;

    assign q_pop = q_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m0[i]  = C0H_W'(COEF_C0) * C0H_W'(h1_reg[i]);
            m1[i]  = C1H_W'(COEF_C1) * C1H_W'(q_data.preload ? accel[i] : h1_reg[i]);
            acc[i] = ACC_W'(m0[i]) + ACC_W'(c1h2_reg[i])
                   + ACC_W'($signed(q_data.c2x[i])) + ROUND_HALF;
            filt[i] = q_data.preload ? accel[i] : sat34(34'(acc[i] >>> FRAC_SHIFT));
        end
    end

    always_comb
    begin
        out_data_next.cal_gyro_x   = q_data.gyro.x;
        out_data_next.cal_gyro_y   = q_data.gyro.y;
        out_data_next.cal_gyro_z   = q_data.gyro.z;
        out_data_next.cal_accel_x  = accel[0];
        out_data_next.cal_accel_y  = accel[1];
        out_data_next.cal_accel_z  = accel[2];
        out_data_next.filt_accel_x = filt[0];
        out_data_next.filt_accel_y = filt[1];
        out_data_next.filt_accel_z = filt[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                h1_reg[i]   <= '0;
                c1h2_reg[i] <= '0;
            end
        end
        else
        begin
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    h1_reg[i]   <= filt[i];
                    c1h2_reg[i] <= m1[i];
                end
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/imr_checker.sv]
// ----------------------------------------------------------------------------
// IMU mount/bias/low-pass: port checker
// Output handshake and transfer accounting seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "imu_mount_rotate_bias_lowpass_defines.svh"

module imr_checker
#(
    parameter int QUEUE_DEPTH = imr_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               out_valid,
    input  logic               out_stall,
    input  imr_pkg::out_item_t out_data
);
    import imr_pkg::*;

    // two front stages, the queue and the output register
    localparam int CAPACITY = QUEUE_DEPTH + 3;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] inflight_reg;
    logic             in_xfer;
    logic             out_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else if (in_xfer && !out_xfer)
            inflight_reg <= inflight_reg + CNT_W'(1);
        else if (out_xfer && !in_xfer)
            inflight_reg <= inflight_reg - CNT_W'(1);
    end

    `IMR_ASSERT(a_out_valid_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
    `IMR_ASSERT(a_out_data_hold, out_valid && out_stall |=> $stable(out_data), "stalled result changed")
    `IMR_ASSERT(a_no_invented, out_valid |-> inflight_reg != '0, "result without an item in flight")
    `IMR_ASSERT_ALWAYS(a_capacity, in_xfer |-> inflight_reg < CNT_W'(CAPACITY), "items beyond capacity")

endmodule

bind imu_mount_rotate_bias_lowpass imr_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_imr_checker (.*);
